@@ rtl/chunked_request_reassembler_macros.svh @@
// assertion macros used by the checker file
// each expects clk and rst_n in scope
`ifndef CHUNKED_REQUEST_REASSEMBLER_MACROS_SVH
`define CHUNKED_REQUEST_REASSEMBLER_MACROS_SVH

// consequent must hold in the same cycle
`define CRR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crr check failed");

// consequent must hold in the following cycle
`define CRR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crr check failed");

`endif

@@ rtl/crr_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crr_pkg
// Shared types, register indexes, status codes and constants of the
// chunked request reassembler.
// ---------------------------------------------------------------------------
package crr_pkg;

    // default sizes
    localparam int BUF_BYTES_DEF = 512;
    localparam int MAX_FRAME_DEF = 512;

    // field widths
    localparam int LIMIT_W    = 10;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int POS_W      = 16;
    localparam int TICK_W     = 32;
    localparam int STATUS_W   = 3;

    // framing constants
    localparam int HDR_IN    = 4;
    localparam int HDR_OUT   = 5;
    localparam int REC_BYTES = 4;
    localparam int LIM_MIN   = 6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LIMIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOTIFY_ENABLED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_BYTE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAP_OPCODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VERSION_BYTE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_TOTAL     = 3'd6;

    // register reset values
    localparam logic [LIMIT_W-1:0] RST_CHUNK_LIMIT   = 10'd20;
    localparam logic [TICK_W-1:0]  RST_TIMEOUT_TICKS = TICK_W'(5 * 1000 * 1000);
    localparam logic [7:0]         RST_TYPE_BYTE     = 8'd6;
    localparam logic [7:0]         RST_CAP_OPCODE    = 8'd0;
    localparam logic [7:0]         RST_VERSION_BYTE  = 8'd1;
    localparam logic [7:0]         RST_SLOT_TOTAL    = 8'd8;

    // response status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MALFORMED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_ACTIVE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ORDER       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 3'd5;

    // configuration register file contents
    typedef struct packed {
        logic [LIMIT_W-1:0] chunk_limit;
        logic               notify_enabled;
        logic [TICK_W-1:0]  timeout_ticks;
        logic [7:0]         type_byte;
        logic [7:0]         capability_opcode;
        logic [7:0]         version_byte;
        logic [7:0]         slot_total;
    } cfg_t;

    // controller to datapath commands
    typedef struct packed {
        logic byte_take;
        logic tick_take;
        logic eval;
        logic emit_step;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic tick_item;
        logic eval_due;
        logic respond;
        logic run_end;
    } dp_stat_t;

endpackage

@@ rtl/chunked_request_reassembler.sv @@
`timescale 1ns / 1ps
// Bytes and ticks are taken while idle; a final byte with notify set adds an evaluation step.
// The first response byte is valid once the controller steps from S_EVAL into S_EMIT.
// A response streams 5 to 24 bytes, one per cycle while out_ready is high; no input meanwhile.
// Rate is set by the evaluation step and the shared response sequencer.
// rst_n clears transfer state, counters and registers to defaults; the store is not cleared.
// ---------------------------------------------------------------------------
// chunked_request_reassembler
// Reassembles chunked request frames, checks them and answers with runs of
// chunked response frames.
// ---------------------------------------------------------------------------
module chunked_request_reassembler
    import crr_pkg::*;
#(
    parameter int BUF_BYTES = BUF_BYTES_DEF,
    parameter int MAX_FRAME = MAX_FRAME_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  cmd,
    input  logic [7:0]            data_byte,
    input  logic                  frame_last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            resp_byte,
    output logic                  frame_end,
    output logic                  run_last
);

    cfg_t     cfg;
    dp_cmd_t  ctl;
    dp_stat_t stat;

    // configuration registers
    crr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // controller
    crr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    // datapath
    crr_dp #(
        .BUF_BYTES (BUF_BYTES),
        .MAX_FRAME (MAX_FRAME)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .ctl        (ctl),
        .stat       (stat),
        .cmd        (cmd),
        .data_byte  (data_byte),
        .frame_last (frame_last),
        .resp_byte  (resp_byte),
        .frame_end  (frame_end),
        .run_last   (run_last)
    );

endmodule

@@ rtl/crr_cfg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crr_cfg
// Configuration register file, written through a plain write port.
// ---------------------------------------------------------------------------
module crr_cfg
    import crr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chunk_limit       <= RST_CHUNK_LIMIT;
            cfg_reg.notify_enabled    <= 1'b0;
            cfg_reg.timeout_ticks     <= RST_TIMEOUT_TICKS;
            cfg_reg.type_byte         <= RST_TYPE_BYTE;
            cfg_reg.capability_opcode <= RST_CAP_OPCODE;
            cfg_reg.version_byte      <= RST_VERSION_BYTE;
            cfg_reg.slot_total        <= RST_SLOT_TOTAL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CHUNK_LIMIT:    cfg_reg.chunk_limit       <= cfg_data[LIMIT_W-1:0];
                REG_NOTIFY_ENABLED: cfg_reg.notify_enabled    <= cfg_data[0];
                REG_TIMEOUT_TICKS:  cfg_reg.timeout_ticks     <= cfg_data[TICK_W-1:0];
                REG_TYPE_BYTE:      cfg_reg.type_byte         <= cfg_data[7:0];
                REG_CAP_OPCODE:     cfg_reg.capability_opcode <= cfg_data[7:0];
                REG_VERSION_BYTE:   cfg_reg.version_byte      <= cfg_data[7:0];
                REG_SLOT_TOTAL:     cfg_reg.slot_total        <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/crr_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crr_ctrl
// Controller: takes items, runs an evaluation state after a final request
// byte with notify enabled and sequences the response stream.
// ---------------------------------------------------------------------------
module crr_ctrl
    import crr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  ctl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && stat.eval_due)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = stat.respond ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (out_ready && stat.run_end)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // handshakes and datapath commands
    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = (state_reg == S_EMIT);
    assign ctl.byte_take = in_ready && in_valid && !stat.tick_item;
    assign ctl.tick_take = in_ready && in_valid && stat.tick_item;
    assign ctl.eval      = (state_reg == S_EVAL);
    assign ctl.emit_step = out_valid && out_ready;

endmodule

@@ rtl/crr_dp.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crr_dp
// Datapath: header capture, payload store, transfer tracking, idle timer,
// request evaluation and response frame generation.
// ---------------------------------------------------------------------------
module crr_dp
    import crr_pkg::*;
#(
    parameter int BUF_BYTES = BUF_BYTES_DEF,
    parameter int MAX_FRAME = MAX_FRAME_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  dp_cmd_t    ctl,
    output dp_stat_t   stat,
    input  logic       cmd,
    input  logic [7:0] data_byte,
    input  logic       frame_last,
    output logic [7:0] resp_byte,
    output logic       frame_end,
    output logic       run_last
);

    localparam int ADDR_W = $clog2(BUF_BYTES);
    localparam int FILL_W = $clog2(BUF_BYTES + 1);
    localparam int SUM_W  = ((FILL_W > POS_W) ? FILL_W : POS_W) + 1;
    localparam int LIM_TOP = (1 << LIMIT_W) - 1;
    localparam int LIM_MAX_I = (MAX_FRAME > LIM_TOP) ? LIM_TOP : MAX_FRAME;
    localparam logic [LIMIT_W-1:0] LIM_MAX  = LIMIT_W'(LIM_MAX_I);
    localparam logic [LIMIT_W-1:0] LIM_LOW  = LIMIT_W'(LIM_MIN);
    localparam logic [LIMIT_W-1:0] LIM_FULL = LIMIT_W'(HDR_OUT + REC_BYTES);
    localparam logic [SUM_W-1:0]   BUF_LIM  = SUM_W'(BUF_BYTES);
    localparam logic [POS_W-1:0]   POS_SAT  = '1;
    localparam logic [TICK_W-1:0]  TICK_SAT = '1;

    // request side registers
    logic [7:0]        hdr_reg [HDR_IN];
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  len_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [7:0]        tid_reg;
    logic [7:0]        top_reg;
    logic [7:0]        exp_reg;
    logic [7:0]        next_reg;
    logic [TICK_W-1:0] idle_reg;
    logic [7:0]        store_mem [BUF_BYTES];

    // response side registers
    logic [7:0]          rid_reg;
    logic [STATUS_W-1:0] rstat_reg;
    logic                rec_en_reg;
    logic [3:0]          bidx_reg;
    logic [1:0]          fidx_reg;
    logic [2:0]          chunks_reg;
    logic [2:0]          rpos_reg;
    logic [2:0]          cl_reg;

    logic [7:0] hdr_id;
    logic [7:0] hdr_op;
    logic [7:0] hdr_idx;
    logic [7:0] hdr_cnt;

    assign hdr_id  = hdr_reg[0];
    assign hdr_op  = hdr_reg[1];
    assign hdr_idx = hdr_reg[2];
    assign hdr_cnt = hdr_reg[3];

    // byte position with saturation
    logic [POS_W-1:0] pos_inc;
    assign pos_inc = (pos_reg != POS_SAT) ? pos_reg + 1'b1 : pos_reg;

    // payload store write qualification
    logic             chunk_match;
    logic             store_ok;
    logic [SUM_W-1:0] store_addr;

    assign chunk_match = (exp_reg != 8'd0) && (hdr_id == tid_reg) && (hdr_op == top_reg)
                         && (hdr_cnt == exp_reg) && (hdr_idx == next_reg);
    assign store_ok    = cfg.notify_enabled && (hdr_cnt != 8'd0) && (hdr_idx < hdr_cnt)
                         && ((hdr_idx == 8'd0) || chunk_match);
    assign store_addr  = ((hdr_idx == 8'd0) ? '0 : SUM_W'(fill_reg))
                         + SUM_W'(pos_reg - POS_W'(HDR_IN));

    always_ff @(posedge clk)
    begin
        if (ctl.byte_take && (pos_reg >= POS_W'(HDR_IN)) && store_ok
            && (store_addr < BUF_LIM))
            store_mem[store_addr[ADDR_W-1:0]] <= data_byte;
    end

    // request evaluation at the end of a frame
    logic              ev_short;
    logic              ev_bad;
    logic              ev_stale;
    logic [7:0]        exp_live;
    logic [7:0]        next_live;
    logic [FILL_W-1:0] fill_live;
    logic              ev_mismatch;
    logic [POS_W-1:0]  plen;
    logic [SUM_W-1:0]  ev_sum;
    logic              ev_over;
    logic [7:0]        next_new;
    logic [7:0]        exp_new;
    logic              ev_done;

    assign ev_short    = (len_reg < POS_W'(HDR_IN));
    assign ev_bad      = (hdr_cnt == 8'd0) || (hdr_idx >= hdr_cnt);
    assign ev_stale    = (exp_reg != 8'd0) && (idle_reg > cfg.timeout_ticks);
    assign exp_live    = ev_stale ? 8'd0 : exp_reg;
    assign next_live   = ev_stale ? 8'd0 : next_reg;
    assign fill_live   = ev_stale ? '0 : fill_reg;
    assign ev_mismatch = (hdr_id != tid_reg) || (hdr_op != top_reg)
                         || (hdr_cnt != exp_live) || (hdr_idx != next_live);
    assign plen        = len_reg - POS_W'(HDR_IN);
    assign ev_sum      = ((hdr_idx == 8'd0) ? '0 : SUM_W'(fill_live)) + SUM_W'(plen);
    assign ev_over     = (ev_sum > BUF_LIM);
    assign next_new    = ((hdr_idx == 8'd0) ? 8'd0 : next_live) + 8'd1;
    assign exp_new     = (hdr_idx == 8'd0) ? hdr_cnt : exp_live;
    assign ev_done     = (next_new >= exp_new);

    logic [7:0]          tid_next;
    logic [7:0]          top_next;
    logic [7:0]          exp_next;
    logic [7:0]          next_next;
    logic [FILL_W-1:0]   fill_next;
    logic                idle_clr;
    logic                ev_resp;
    logic [STATUS_W-1:0] ev_status;
    logic                ev_rec;

    always_comb
    begin
        tid_next  = tid_reg;
        top_next  = top_reg;
        exp_next  = exp_reg;
        next_next = next_reg;
        fill_next = fill_reg;
        idle_clr  = 1'b0;
        ev_resp   = 1'b0;
        ev_status = ST_OK;
        ev_rec    = 1'b0;
        if (ev_short || ev_bad)
        begin
            ev_resp   = 1'b1;
            ev_status = ST_MALFORMED;
        end
        else
        begin
            exp_next  = exp_live;
            next_next = next_live;
            fill_next = fill_live;
            if (hdr_idx == 8'd0)
            begin
                tid_next = hdr_id;
                top_next = hdr_op;
            end
            if ((hdr_idx != 8'd0) && (exp_live == 8'd0))
            begin
                ev_resp   = 1'b1;
                ev_status = ST_NO_ACTIVE;
            end
            else if ((hdr_idx != 8'd0) && ev_mismatch)
            begin
                exp_next  = 8'd0;
                next_next = 8'd0;
                fill_next = '0;
                ev_resp   = 1'b1;
                ev_status = ST_ORDER;
            end
            else if (ev_over)
            begin
                exp_next  = 8'd0;
                next_next = 8'd0;
                fill_next = '0;
                ev_resp   = 1'b1;
                ev_status = ST_TOO_LARGE;
            end
            else
            begin
                exp_next  = exp_new;
                next_next = next_new;
                fill_next = ev_sum[FILL_W-1:0];
                idle_clr  = 1'b1;
                if (ev_done)
                begin
                    exp_next  = 8'd0;
                    next_next = 8'd0;
                    fill_next = '0;
                    ev_resp   = 1'b1;
                    ev_rec    = (hdr_op == cfg.capability_opcode);
                    ev_status = ev_rec ? ST_OK : ST_UNSUPPORTED;
                end
            end
        end
    end

    // request side state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HDR_IN; i++)
                hdr_reg[i] <= 8'd0;
            pos_reg  <= '0;
            len_reg  <= '0;
            fill_reg <= '0;
            tid_reg  <= 8'd0;
            top_reg  <= 8'd0;
            exp_reg  <= 8'd0;
            next_reg <= 8'd0;
            idle_reg <= '0;
        end
        else
        begin
            if (ctl.byte_take)
            begin
                if (pos_reg < POS_W'(HDR_IN))
                    hdr_reg[pos_reg[1:0]] <= data_byte;
                if (frame_last)
                begin
                    pos_reg <= '0;
                    len_reg <= pos_inc;
                end
                else
                begin
                    pos_reg <= pos_inc;
                end
            end
            if (ctl.tick_take && (idle_reg != TICK_SAT))
                idle_reg <= idle_reg + 1'b1;
            if (ctl.eval)
            begin
                tid_reg  <= tid_next;
                top_reg  <= top_next;
                exp_reg  <= exp_next;
                next_reg <= next_next;
                fill_reg <= fill_next;
                if (idle_clr)
                    idle_reg <= '0;
            end
        end
    end

    // effective frame limit and payload bytes per frame, capped at the record size
    logic [LIMIT_W-1:0] lim_hi;
    logic [LIMIT_W-1:0] eff_lim;
    logic [2:0]         per4;
    logic [2:0]         chunks_calc;

    assign lim_hi      = (cfg.chunk_limit > LIM_MAX) ? LIM_MAX : cfg.chunk_limit;
    assign eff_lim     = (lim_hi < LIM_LOW) ? LIM_LOW : lim_hi;
    assign per4        = (eff_lim >= LIM_FULL) ? 3'(REC_BYTES)
                                               : 3'(eff_lim - LIMIT_W'(HDR_OUT));
    assign chunks_calc = (per4 == 3'(REC_BYTES)) ? 3'd1 : ((per4 == 3'd1) ? 3'd4 : 3'd2);

    // current response byte
    logic       in_hdr;
    logic [7:0] hdr_byte;
    logic [7:0] rec_byte;

    assign in_hdr = (bidx_reg < 4'(HDR_OUT));

    always_comb
    begin
        case (bidx_reg)
            4'd0:    hdr_byte = cfg.type_byte;
            4'd1:    hdr_byte = rid_reg;
            4'd2:    hdr_byte = 8'(rstat_reg);
            4'd3:    hdr_byte = 8'(fidx_reg);
            default: hdr_byte = 8'(chunks_reg);
        endcase
    end

    always_comb
    begin
        case (rpos_reg)
            3'd0:    rec_byte = cfg.version_byte;
            3'd1:    rec_byte = cfg.slot_total;
            3'd2:    rec_byte = 8'(eff_lim[LIMIT_W-1:8]);
            default: rec_byte = eff_lim[7:0];
        endcase
    end

    assign resp_byte = in_hdr ? hdr_byte : rec_byte;
    assign frame_end = (bidx_reg == 4'(HDR_OUT - 1) + 4'(cl_reg));
    assign run_last  = frame_end && ((3'(fidx_reg) + 3'd1) == chunks_reg);

    // response sequencing counters
    logic [2:0] rpos_after;
    logic [2:0] rec_left;

    assign rpos_after = rpos_reg + (in_hdr ? 3'd0 : 3'd1);
    assign rec_left   = 3'(REC_BYTES) - rpos_after;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rid_reg    <= 8'd0;
            rstat_reg  <= ST_OK;
            rec_en_reg <= 1'b0;
            bidx_reg   <= 4'd0;
            fidx_reg   <= 2'd0;
            chunks_reg <= 3'd1;
            rpos_reg   <= 3'd0;
            cl_reg     <= 3'd0;
        end
        else if (ctl.eval)
        begin
            rid_reg    <= hdr_id;
            rstat_reg  <= ev_status;
            rec_en_reg <= ev_rec;
            bidx_reg   <= 4'd0;
            fidx_reg   <= 2'd0;
            chunks_reg <= ev_rec ? chunks_calc : 3'd1;
            rpos_reg   <= 3'd0;
            cl_reg     <= ev_rec ? per4 : 3'd0;
        end
        else if (ctl.emit_step)
        begin
            rpos_reg <= rpos_after;
            if (frame_end)
            begin
                bidx_reg <= 4'd0;
                fidx_reg <= fidx_reg + 2'd1;
                if (rec_en_reg)
                    cl_reg <= (per4 < rec_left) ? per4 : rec_left;
                else
                    cl_reg <= 3'd0;
            end
            else
            begin
                bidx_reg <= bidx_reg + 4'd1;
            end
        end
    end

    // status toward the controller
    assign stat.tick_item = cmd;
    assign stat.eval_due  = !cmd && frame_last && cfg.notify_enabled;
    assign stat.respond   = ev_resp;
    assign stat.run_end   = run_last;

endmodule

@@ rtl/crr_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crr_checker
// Port level checks of the chunked request reassembler, bound to the top.
// ---------------------------------------------------------------------------
`include "chunked_request_reassembler_macros.svh"

module crr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       cmd,
    input logic       out_valid,
    input logic       out_ready,
    input logic       frame_end,
    input logic       run_last
);

    // the last byte of a response always closes a frame
    `CRR_ASSERT_NOW(a_run_last_ends_frame, out_valid && run_last, frame_end)

    // no request transaction while a response is streaming
    `CRR_ASSERT_NOW(a_no_input_while_emit, out_valid, !in_ready)

    // output goes quiet after the final response transaction
    `CRR_ASSERT_NEXT(a_idle_after_run, out_valid && out_ready && run_last, !out_valid)

    // a tick never starts a response
    `CRR_ASSERT_NEXT(a_tick_silent, in_valid && in_ready && cmd, !out_valid)

    // stalled response keeps its framing marks
    `CRR_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(frame_end) && $stable(run_last))

endmodule

bind chunked_request_reassembler crr_checker u_crr_checker (.*);
